/* rtl/core/uls_pkg.sv */
// Shared types, character codes and helper functions for the line splitter.
package uls_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  localparam logic [31:0] CH_LF  = 32'h0000_000A;
  localparam logic [31:0] CH_VT  = 32'h0000_000B;
  localparam logic [31:0] CH_FF  = 32'h0000_000C;
  localparam logic [31:0] CH_CR  = 32'h0000_000D;
  localparam logic [31:0] CH_NEL = 32'h0000_0085;
  localparam logic [31:0] CH_LS  = 32'h0000_2028;
  localparam logic [31:0] CH_PS  = 32'h0000_2029;

  localparam logic [3:0] KIND_NONE = 4'd0;
  localparam logic [3:0] KIND_LF   = 4'd1;
  localparam logic [3:0] KIND_VT   = 4'd2;
  localparam logic [3:0] KIND_FF   = 4'd3;
  localparam logic [3:0] KIND_CR   = 4'd4;
  localparam logic [3:0] KIND_CRLF = 4'd5;
  localparam logic [3:0] KIND_NEL  = 4'd6;
  localparam logic [3:0] KIND_LS   = 4'd7;
  localparam logic [3:0] KIND_PS   = 4'd8;

  typedef struct packed {
    logic [31:0] line_number;
    logic [31:0] start_offset;
    logic [31:0] text_length;
    logic [31:0] line_length;
    logic [3:0]  ending_kind;
    logic        run_end;
  } result_t;

  // up to two lines per input word, emitted a first then b
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } step_out_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [1:0] b);
    logic [32:0] s;
    begin
      s = {1'b0, a} + {31'd0, b};
      sat_add32 = s[32] ? 32'hFFFF_FFFF : s[31:0];
    end
  endfunction

  function automatic logic [3:0] single_kind(input logic [31:0] w);
    begin
      case (w)
        CH_LF:   single_kind = KIND_LF;
        CH_VT:   single_kind = KIND_VT;
        CH_FF:   single_kind = KIND_FF;
        CH_NEL:  single_kind = KIND_NEL;
        CH_LS:   single_kind = KIND_LS;
        CH_PS:   single_kind = KIND_PS;
        default: single_kind = KIND_NONE;
      endcase
    end
  endfunction

endpackage

/* rtl/core/uls_step.sv */
// Line splitting state and the per-word line results.
module uls_step #(
  parameter int OFFSET_BITS = uls_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [31:0]       code_word,
  input  logic              final_word,
  output uls_pkg::step_out_t res
);
  import uls_pkg::*;

  logic                   cr_pending;
  logic [OFFSET_BITS-1:0] word_position;
  logic [31:0]            text_count;
  logic [31:0]            line_counter;

  logic                   cr_pending_next;
  logic [OFFSET_BITS-1:0] word_position_next;
  logic [31:0]            text_count_next;
  logic [31:0]            line_counter_next;

  logic [3:0]  kind;
  logic        is_lf;
  logic        is_cr;
  logic        done;
  logic        end_emit;
  logic        trail_emit;
  logic [31:0] pos32;
  logic [31:0] pos_inc32;
  logic [31:0] lc1;
  logic [31:0] tc1;

  always_comb begin
    kind  = single_kind(code_word);
    is_lf = (code_word == CH_LF);
    is_cr = (code_word == CH_CR);
    pos32 = 32'(word_position);
    word_position_next = (word_position == {OFFSET_BITS{1'b1}}) ? word_position
                                                                : word_position + 1'b1;
    pos_inc32 = 32'(word_position_next);

    // pending CR line
    res.a_valid         = cr_pending;
    res.a.line_number   = line_counter;
    res.a.start_offset  = pos32 - 32'd1 - text_count;
    res.a.text_length   = text_count;
    res.a.line_length   = sat_add32(text_count, is_lf ? 2'd2 : 2'd1);
    res.a.ending_kind   = is_lf ? KIND_CRLF : KIND_CR;

    lc1  = cr_pending ? sat_add32(line_counter, 2'd1) : line_counter;
    tc1  = cr_pending ? 32'd0 : text_count;
    done = cr_pending && is_lf;

    end_emit = !done && ((kind != KIND_NONE) || (is_cr && final_word));
    if (done || end_emit) begin
      text_count_next = 32'd0;
    end else if (is_cr) begin
      text_count_next = tc1;
    end else begin
      text_count_next = sat_add32(tc1, 2'd1);
    end
    trail_emit = !done && final_word && (text_count_next != 32'd0);

    res.b_valid        = end_emit || trail_emit;
    res.b.line_number  = lc1;
    res.b.start_offset = end_emit ? pos32 - tc1 : pos_inc32 - text_count_next;
    res.b.text_length  = end_emit ? tc1 : text_count_next;
    res.b.line_length  = end_emit ? sat_add32(tc1, 2'd1) : text_count_next;
    res.b.ending_kind  = end_emit ? ((kind != KIND_NONE) ? kind : KIND_CR) : KIND_NONE;
    res.b.run_end      = 1'b1;
    res.a.run_end      = !res.b_valid;

    line_counter_next = res.b_valid ? sat_add32(lc1, 2'd1) : lc1;
    cr_pending_next   = !done && is_cr && !final_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending    <= 1'b0;
      word_position <= '0;
      text_count    <= 32'd0;
      line_counter  <= 32'd0;
    end else if (fire) begin
      if (final_word) begin
        cr_pending    <= 1'b0;
        word_position <= '0;
        text_count    <= 32'd0;
        line_counter  <= 32'd0;
      end else begin
        cr_pending    <= cr_pending_next;
        word_position <= word_position_next;
        text_count    <= text_count_next;
        line_counter  <= line_counter_next;
      end
    end
  end

endmodule

/* rtl/core/uls_out.sv */
// Result register with a spare slot for the second line of a word.
module uls_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  uls_pkg::step_out_t res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output uls_pkg::result_t   out_data
);
  import uls_pkg::*;

  logic    spare_valid;
  result_t spare;
  logic    out_free;

  assign out_free = !out_valid || out_ready;
  assign ready    = !spare_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (load) begin
      out_valid   <= res.a_valid || res.b_valid;
      spare_valid <= res.a_valid && res.b_valid;
    end else if (spare_valid && out_free) begin
      out_valid   <= 1'b1;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res.a_valid ? res.a : res.b;
      spare    <= res.b;
    end else if (spare_valid && out_free) begin
      out_data <= spare;
    end
  end

endmodule

/* rtl/core/unicode_line_splitter_core.sv */
// Top level of the line splitter: input register, line logic, result register.
//
//  channel | dir | tdata                                    | tuser       | tlast
//  s_*     | in  | code_word[31:0]                          | -           | final_word
//  m_*     | out | line_number, start_offset, text_length,  | ending_kind | run_end
//          |     | line_length (32 bits each, low to high)  |             |
//
// A word goes from the input register through the line logic into the result
// register; one word per cycle while the output does not stall and each word yields
// at most one line. A word that yields two holds the next back while the spare result slot drains.
// Reset (rst, synchronous) clears counters, pending CR and all valid flags.
// Output stalls propagate back to s_tready through the input register.
module unicode_line_splitter_core #(
  parameter int OFFSET_BITS = uls_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] code_word
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // line_number, start_offset, text_length, line_length
  output logic [3:0]   m_tuser,   // [3:0] ending_kind
  output logic         m_tlast
);
  import uls_pkg::*;

  logic        in_valid;
  logic [31:0] in_word;
  logic        in_final;
  logic        out_ready_int;
  logic        consume;
  step_out_t   step_res;
  result_t     out_data;

  assign consume  = in_valid && out_ready_int;
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (consume) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  uls_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (consume),
    .code_word  (in_word),
    .final_word (in_final),
    .res        (step_res)
  );

  uls_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (consume),
    .res       (step_res),
    .ready     (out_ready_int),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {out_data.line_length, out_data.text_length,
                    out_data.start_offset, out_data.line_number};
  assign m_tuser = out_data.ending_kind;
  assign m_tlast = out_data.run_end;

endmodule

/* sim/tb_unicode_line_splitter_core.sv */
// Testbench for unicode_line_splitter_core: directed and random streams with a line predictor.
`timescale 1ns / 1ps

module tb_unicode_line_splitter_core;
  import uls_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_WORDS = 1400;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = 32'd0;   // [31:0] code_word
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;           // line_number, start_offset, text_length, line_length
  logic [3:0]   m_tuser;           // [3:0] ending_kind
  logic         m_tlast;

  unicode_line_splitter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // predictor state
  logic        cr_open = 1'b0;
  logic [31:0] word_pos = 32'd0;
  logic [31:0] text_cnt = 32'd0;
  logic [31:0] line_cnt = 32'd0;
  result_t     line_q [$];
  result_t     want_line;

  bit          src_idle = 1'b0;
  bit          sink_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          sink_wait = 0;
  int          sink_hold_len = 0;
  int          quiet_cycles = 0;
  int          fail_count = 0;
  int          words_sent = 0;
  int          runs_sent = 0;
  int          lines_checked = 0;
  int          kind_hits [9];
  logic [31:0] run_words [$];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic add_line(input logic [31:0] start, input logic [1:0] extra,
                          input logic [3:0] kind);
    result_t r;
    logic [32:0] total;
    total = {1'b0, text_cnt} + {31'd0, extra};
    r.line_number  = line_cnt;
    r.start_offset = start;
    r.text_length  = text_cnt;
    r.line_length  = total[32] ? 32'hFFFF_FFFF : total[31:0];
    r.ending_kind  = kind;
    r.run_end      = 1'b0;
    line_q.push_back(r);
    if (line_cnt != 32'hFFFF_FFFF) line_cnt = line_cnt + 32'd1;
    text_cnt = 32'd0;
  endtask

  // lines produced by one accepted code word
  task automatic split_word(input logic [31:0] w, input logic fin);
    int          n0;
    bit          taken;
    logic [3:0]  kind;
    n0 = line_q.size();
    taken = 1'b0;
    if (cr_open) begin
      cr_open = 1'b0;
      if (w == CH_LF) begin
        add_line(word_pos - 32'd1 - text_cnt, 2'd2, KIND_CRLF);
        if (word_pos != 32'hFFFF_FFFF) word_pos = word_pos + 32'd1;
        taken = 1'b1;
      end else begin
        add_line(word_pos - 32'd1 - text_cnt, 2'd1, KIND_CR);
      end
    end
    if (!taken) begin
      case (w)
        CH_LF:   kind = KIND_LF;
        CH_VT:   kind = KIND_VT;
        CH_FF:   kind = KIND_FF;
        CH_NEL:  kind = KIND_NEL;
        CH_LS:   kind = KIND_LS;
        CH_PS:   kind = KIND_PS;
        default: kind = KIND_NONE;
      endcase
      if (kind != KIND_NONE) begin
        add_line(word_pos - text_cnt, 2'd1, kind);
      end else if (w == CH_CR) begin
        if (fin) add_line(word_pos - text_cnt, 2'd1, KIND_CR);
        else cr_open = 1'b1;
      end else if (text_cnt != 32'hFFFF_FFFF) begin
        text_cnt = text_cnt + 32'd1;
      end
      if (word_pos != 32'hFFFF_FFFF) word_pos = word_pos + 32'd1;
      if (fin && text_cnt != 32'd0) add_line(word_pos - text_cnt, 2'd0, KIND_NONE);
    end
    if (line_q.size() > n0) line_q[line_q.size() - 1].run_end = 1'b1;
    if (fin) begin
      cr_open  = 1'b0;
      word_pos = 32'd0;
      text_cnt = 32'd0;
      line_cnt = 32'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  // result check first, then prediction for the word accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (line_q.size() == 0) begin
          $error("line result with none expected: tdata 0x%032h tuser %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want_line = line_q.pop_front();
          check_field("line_number", want_line.line_number, m_tdata[31:0]);
          check_field("start_offset", want_line.start_offset, m_tdata[63:32]);
          check_field("text_length", want_line.text_length, m_tdata[95:64]);
          check_field("line_length", want_line.line_length, m_tdata[127:96]);
          check_field("ending_kind", 32'(want_line.ending_kind), 32'(m_tuser));
          check_field("run_end", 32'(want_line.run_end), 32'(m_tlast));
          lines_checked++;
          if (m_tuser <= KIND_PS) kind_hits[m_tuser]++;
        end
      end
      if (s_tvalid && s_tready) split_word(s_tdata, s_tlast);
    end
  end

  // output side: per-result stall, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      m_tready <= 1'b0;
      sink_hold_len <= HOLD_CYCLES - 1;
    end else if (sink_hold_len > 0) begin
      m_tready <= 1'b0;
      sink_hold_len <= sink_hold_len - 1;
    end else if (m_tvalid && m_tready) begin
      sink_wait = sink_idle ? $urandom_range(0, 6) : 0;
      m_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait = sink_wait - 1;
      m_tready <= (sink_wait == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("unicode_line_splitter_core test failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [31:0] w, input logic fin);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    if (fin) runs_sent++;
  endtask

  task automatic send_run();
    for (int i = 0; i < run_words.size(); i++)
      send_word(run_words[i], i == run_words.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 15))
      0:  return CH_LF;
      1:  return CH_VT;
      2:  return CH_FF;
      3:  return CH_CR;
      4:  return CH_CR;
      5:  return CH_NEL;
      6:  return CH_LS;
      7:  return CH_PS;
      8:  return CH_CR | (32'h1 << $urandom_range(4, 31));
      9: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_2027;
          1:       return 32'h0000_202A;
          2:       return 32'h0000_0084;
          default: return 32'h0000_000E;
        endcase
      end
      10: return $urandom;
      11: return $urandom;
      default: return 32'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic test_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  endtask

  task automatic test_each_ending();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_words = '{32'h41, CH_LF, CH_VT, CH_FF, CH_NEL, CH_LS, CH_PS, 32'h42,
                  CH_CR, CH_LF, CH_CR, 32'h43, CH_CR, CH_CR, 32'hFFFF_FFFF};
    send_run();
    drain();
  endtask

  task automatic test_cr_handling();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_words = '{CH_CR, CH_LF};        // CRLF on the last word
    send_run();
    run_words = '{32'h78, CH_CR, 32'h79}; // pending CR, then trailing text
    send_run();
    drain();
  endtask

  task automatic test_final_word();
    run_words = '{32'h0001_000D, CH_CR}; // CR look-alike, then CR on the last word
    send_run();
    run_words = '{CH_LF};
    send_run();
    run_words = '{32'h0};
    send_run();
    drain();
  endtask

  task automatic test_random();
    int  len;
    int  start_count;
    bit  pair_next;
    logic [31:0] w;
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
      pair_next = 1'b0;
      for (int i = 0; i < len; i++) begin
        w = pair_next ? CH_LF : random_word();
        pair_next = (w == CH_CR) && ($urandom_range(0, 1) == 1);
        send_word(w, i == len - 1);
      end
    end
    drain();
  endtask

  task automatic test_output_hold();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++)
      send_word((i % 3 == 2) ? CH_LF : $urandom, i == 39);
    drain();
  endtask

  initial begin
    int kinds_seen;
    test_reset();
    test_each_ending();
    test_cr_handling();
    test_final_word();
    test_random();
    test_output_hold();
    kinds_seen = 0;
    foreach (kind_hits[k]) if (kind_hits[k] > 0) kinds_seen++;
    $display("Run covered %0d code words in %0d streams; %0d lines checked, %0d of 9 ending kinds.",
             words_sent, runs_sent, lines_checked, kinds_seen);
    $display("Included random gaps on both sides and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (fail_count == 0 && line_q.size() == 0) begin
      $display("unicode_line_splitter_core test passed");
    end else begin
      $display("unicode_line_splitter_core test failed");
    end
    $finish;
  end

endmodule
